[rtl/prot_pkg.sv]
// shared types and constants for the 3x2 polar rotation pipeline
package prot_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int IN_DATA_W = 192;
  localparam int OUT_DATA_W = 256;
  localparam int SIG_W = 31;

  typedef struct packed {
    logic en;
    logic vld;
  } ctl_t;

endpackage

[rtl/prot_isqrt.sv]
// pipelined floor square root, one result bit per stage, several lanes sharing a side payload
module prot_isqrt #(
  parameter int LANES = 1,
  parameter int IN_W = 128,
  parameter int SIDE_W = 1
) (
  input  logic                                clk,
  input  logic                                rst,
  input  prot_pkg::ctl_t                      ctl,
  input  logic [LANES-1:0][IN_W-1:0]          rad,
  input  logic [SIDE_W-1:0]                   side_in,
  output logic                                vld_out,
  output logic [LANES-1:0][IN_W/2-1:0]        root,
  output logic [SIDE_W-1:0]                   side_out
);

  localparam int RW = IN_W / 2;
  localparam int REM_W = RW + 2;

  logic                         vld_r  [RW];
  logic [LANES-1:0][IN_W-1:0]   v_r    [RW];
  logic [LANES-1:0][REM_W-1:0]  rem_r  [RW];
  logic [LANES-1:0][RW-1:0]     rt_r   [RW];
  logic [SIDE_W-1:0]            side_r [RW];

  for (genvar s = 0; s < RW; s++) begin : g_step
    logic                         p_vld;
    logic [LANES-1:0][IN_W-1:0]   p_v;
    logic [LANES-1:0][REM_W-1:0]  p_rem;
    logic [LANES-1:0][RW-1:0]     p_rt;
    logic [SIDE_W-1:0]            p_side;
    logic [LANES-1:0][IN_W-1:0]   n_v;
    logic [LANES-1:0][REM_W-1:0]  n_rem;
    logic [LANES-1:0][RW-1:0]     n_rt;

    if (s == 0) begin : g_first
      assign p_vld  = ctl.vld;
      assign p_v    = rad;
      assign p_rem  = '0;
      assign p_rt   = '0;
      assign p_side = side_in;
    end else begin : g_next
      assign p_vld  = vld_r[s-1];
      assign p_v    = v_r[s-1];
      assign p_rem  = rem_r[s-1];
      assign p_rt   = rt_r[s-1];
      assign p_side = side_r[s-1];
    end

    always_comb begin
      for (int l = 0; l < LANES; l++) begin
        logic [REM_W-1:0] rsh;
        logic [REM_W-1:0] trial;
        logic             ge;
        rsh = {p_rem[l][REM_W-3:0], p_v[l][IN_W-1 -: 2]};
        trial = {p_rt[l], 2'b01};
        ge = (rsh >= trial);
        n_rem[l] = ge ? rsh - trial : rsh;
        n_rt[l] = {p_rt[l][RW-2:0], ge};
        n_v[l] = p_v[l] << 2;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_r[s] <= 1'b0;
      end else if (ctl.en) begin
        vld_r[s] <= p_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (ctl.en) begin
        v_r[s]    <= n_v;
        rem_r[s]  <= n_rem;
        rt_r[s]   <= n_rt;
        side_r[s] <= p_side;
      end
    end
  end

  assign vld_out  = vld_r[RW-1];
  assign root     = rt_r[RW-1];
  assign side_out = side_r[RW-1];

endmodule

[rtl/prot_div.sv]
// pipelined restoring divider with overflow flag, one quotient bit per stage, shared divisor
module prot_div #(
  parameter int LANES = 6,
  parameter int N_W = 128,
  parameter int D_W = 97,
  parameter int Q_W = 32,
  parameter int SIDE_W = 1
) (
  input  logic                         clk,
  input  logic                         rst,
  input  prot_pkg::ctl_t               ctl,
  input  logic [LANES-1:0][N_W-1:0]    num,
  input  logic [D_W-1:0]               dvs,
  input  logic [SIDE_W-1:0]            side_in,
  output logic                         vld_out,
  output logic [LANES-1:0][Q_W-1:0]    quo,
  output logic [LANES-1:0]             ovf,
  output logic [SIDE_W-1:0]            side_out
);

  logic                        vld_r  [Q_W+1];
  logic [LANES-1:0][D_W-1:0]   rem_r  [Q_W+1];
  logic [LANES-1:0][Q_W-1:0]   low_r  [Q_W+1];
  logic [LANES-1:0][Q_W-1:0]   q_r    [Q_W+1];
  logic [LANES-1:0]            ovf_r  [Q_W+1];
  logic [D_W-1:0]              d_r    [Q_W+1];
  logic [SIDE_W-1:0]           side_r [Q_W+1];

  // quotient fits only if the high part of the numerator is below the divisor
  always_ff @(posedge clk) begin
    if (rst) begin
      vld_r[0] <= 1'b0;
    end else if (ctl.en) begin
      vld_r[0] <= ctl.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      for (int l = 0; l < LANES; l++) begin
        rem_r[0][l] <= D_W'(num[l][N_W-1:Q_W]);
        low_r[0][l] <= num[l][Q_W-1:0];
        ovf_r[0][l] <= (D_W'(num[l][N_W-1:Q_W]) >= dvs);
      end
      q_r[0]    <= '0;
      d_r[0]    <= dvs;
      side_r[0] <= side_in;
    end
  end

  for (genvar s = 1; s <= Q_W; s++) begin : g_step
    logic [LANES-1:0][D_W-1:0] n_rem;
    logic [LANES-1:0][Q_W-1:0] n_q;
    logic [LANES-1:0][Q_W-1:0] n_low;

    always_comb begin
      for (int l = 0; l < LANES; l++) begin
        logic [D_W:0] r2;
        logic         ge;
        r2 = {rem_r[s-1][l], low_r[s-1][l][Q_W-1]};
        ge = (r2 >= {1'b0, d_r[s-1]});
        n_rem[l] = ge ? D_W'(r2 - {1'b0, d_r[s-1]}) : D_W'(r2);
        n_q[l] = {q_r[s-1][l][Q_W-2:0], ge};
        n_low[l] = low_r[s-1][l] << 1;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_r[s] <= 1'b0;
      end else if (ctl.en) begin
        vld_r[s] <= vld_r[s-1];
      end
    end

    always_ff @(posedge clk) begin
      if (ctl.en) begin
        rem_r[s]  <= n_rem;
        low_r[s]  <= n_low;
        q_r[s]    <= n_q;
        ovf_r[s]  <= ovf_r[s-1];
        d_r[s]    <= d_r[s-1];
        side_r[s] <= side_r[s-1];
      end
    end
  end

  assign vld_out  = vld_r[Q_W];
  assign quo      = q_r[Q_W];
  assign ovf      = ovf_r[Q_W];
  assign side_out = side_r[Q_W];

endmodule

[rtl/polar_rotation_3x2.sv]
// top level: nearest 3x2 rotation and singular values of a triangle's deformation gradient
//
//   channel  | dir | fields (low bit up)
//   ---------+-----+--------------------------------------------------------------
//   s_*      | in  | f_xu f_xv f_yu f_yv f_zu f_zv, 32 bits each
//   m_*      | out | r_xu r_xv r_yu r_yv r_zu r_zv (32 each), sig_major, sig_minor (31)
//
// one transfer per cycle in each direction while the output is not stalled
// the longest sections are the 64-stage root of det C, the 33-stage roots of the
// singular value sum and difference, and the 33-stage rotation divider
// reset clears the valid bits only
// a stalled output freezes the whole pipeline, nothing is dropped or repeated
module polar_rotation_3x2 #(
  parameter int FRAC_BITS = prot_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // f_xu, f_xv, f_yu, f_yv, f_zu, f_zv
  input  logic [prot_pkg::IN_DATA_W-1:0]      s_tdata,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // r_xu, r_xv, r_yu, r_yv, r_zu, r_zv, sig_major, sig_minor, 2 zero bits
  output logic [prot_pkg::OUT_DATA_W-1:0]     m_tdata
);

  localparam int CI [3] = '{1, 2, 0};
  localparam int CJ [3] = '{2, 0, 1};
  localparam int SIDE_A_W = 66 + 64 + 64 + prot_pkg::IN_DATA_W;
  localparam int SIDE_B_W = 64 + 66 + 65 + 65 + prot_pkg::IN_DATA_W;
  localparam int SIDE_D_W = 6 + 2 * prot_pkg::SIG_W;

  logic en;
  assign en = !m_tvalid || m_tready;
  assign s_tready = en;

  // stage 1: input register
  logic v1;
  logic [prot_pkg::IN_DATA_W-1:0] f1;
  logic signed [31:0] a1 [3];
  logic signed [31:0] b1 [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f1 <= s_tdata;
    end
  end

  always_comb begin
    for (int d = 0; d < 3; d++) begin
      a1[d] = f1[64*d +: 32];
      b1[d] = f1[64*d+32 +: 32];
    end
  end

  // stage 2: entry products
  logic v2;
  logic [prot_pkg::IN_DATA_W-1:0] f2;
  logic signed [63:0] sqa2 [3];
  logic signed [63:0] sqb2 [3];
  logic signed [63:0] ab2  [3];
  logic signed [63:0] crp2 [3];
  logic signed [63:0] crn2 [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f2 <= f1;
      for (int d = 0; d < 3; d++) begin
        sqa2[d] <= a1[d] * a1[d];
        sqb2[d] <= b1[d] * b1[d];
        ab2[d]  <= a1[d] * b1[d];
        crp2[d] <= a1[CI[d]] * b1[CJ[d]];
        crn2[d] <= a1[CJ[d]] * b1[CI[d]];
      end
    end
  end

  // stage 3: entries of C and cross product magnitudes
  logic v3;
  logic [prot_pkg::IN_DATA_W-1:0] f3;
  logic [63:0] c00_3;
  logic [63:0] c11_3;
  logic signed [65:0] c01_3;
  logic [63:0] m3 [3];
  logic [63:0] m_n [3];

  always_comb begin
    for (int d = 0; d < 3; d++) begin
      logic signed [64:0] x;
      x = 65'(crp2[d]) - 65'(crn2[d]);
      m_n[d] = x[64] ? 64'(-x) : x[63:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f3    <= f2;
      c00_3 <= $unsigned(sqa2[0]) + $unsigned(sqa2[1]) + $unsigned(sqa2[2]);
      c11_3 <= $unsigned(sqb2[0]) + $unsigned(sqb2[1]) + $unsigned(sqb2[2]);
      c01_3 <= 66'(ab2[0]) + 66'(ab2[1]) + 66'(ab2[2]);
      for (int d = 0; d < 3; d++) begin
        m3[d] <= m_n[d];
      end
    end
  end

  // stage 4: partial products of the squared magnitudes
  logic v4;
  logic [prot_pkg::IN_DATA_W-1:0] f4;
  logic [63:0] c00_4;
  logic [63:0] c11_4;
  logic signed [65:0] c01_4;
  logic [63:0] phh4 [3];
  logic [63:0] phl4 [3];
  logic [63:0] pll4 [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (en) begin
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f4    <= f3;
      c00_4 <= c00_3;
      c11_4 <= c11_3;
      c01_4 <= c01_3;
      for (int d = 0; d < 3; d++) begin
        phh4[d] <= m3[d][63:32] * m3[d][63:32];
        phl4[d] <= m3[d][63:32] * m3[d][31:0];
        pll4[d] <= m3[d][31:0] * m3[d][31:0];
      end
    end
  end

  // stage 5: squared magnitudes
  logic v5;
  logic [prot_pkg::IN_DATA_W-1:0] f5;
  logic [63:0] c00_5;
  logic [63:0] c11_5;
  logic signed [65:0] c01_5;
  logic [127:0] sq5 [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (en) begin
      v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f5    <= f4;
      c00_5 <= c00_4;
      c11_5 <= c11_4;
      c01_5 <= c01_4;
      for (int d = 0; d < 3; d++) begin
        sq5[d] <= {phh4[d], 64'b0} + {31'b0, phl4[d], 33'b0} + {64'b0, pll4[d]};
      end
    end
  end

  // stage 6: det C with 4*FRAC fraction bits
  logic v6;
  logic [127:0] acc6;
  logic [SIDE_A_W-1:0] side_a6;

  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
    end else if (en) begin
      v6 <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      acc6    <= sq5[0] + sq5[1] + sq5[2];
      side_a6 <= {c01_5, c11_5, c00_5, f5};
    end
  end

  // root of det C
  logic va;
  logic [63:0] sd_a;
  logic [SIDE_A_W-1:0] side_a;
  logic [prot_pkg::IN_DATA_W-1:0] fa;
  logic [63:0] c00_a;
  logic [63:0] c11_a;
  logic signed [65:0] c01_a;

  prot_isqrt #(
    .LANES (1),
    .IN_W  (128),
    .SIDE_W(SIDE_A_W)
  ) u_sqrt_det (
    .clk     (clk),
    .rst     (rst),
    .ctl     ('{en: en, vld: v6}),
    .rad     (acc6),
    .side_in (side_a6),
    .vld_out (va),
    .root    (sd_a),
    .side_out(side_a)
  );

  assign {c01_a, c11_a, c00_a, fa} = side_a;

  // stage 7: radicands for the singular value sum and difference, adjugate diagonal
  logic v7;
  logic [1:0][65:0] rad7;
  logic [SIDE_B_W-1:0] side_b7;
  logic [64:0] tr_n;
  logic [64:0] sd2_n;

  assign tr_n  = {1'b0, c00_a} + {1'b0, c11_a};
  assign sd2_n = {sd_a, 1'b0};

  always_ff @(posedge clk) begin
    if (rst) begin
      v7 <= 1'b0;
    end else if (en) begin
      v7 <= va;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rad7[0] <= {1'b0, tr_n} + {1'b0, sd2_n};
      rad7[1] <= (tr_n >= sd2_n) ? {1'b0, tr_n - sd2_n} : 66'd0;
      side_b7 <= {(sd_a == 64'd0) ? 64'd1 : sd_a, c01_a,
                  {1'b0, c00_a} + {1'b0, sd_a}, {1'b0, c11_a} + {1'b0, sd_a}, fa};
    end
  end

  // roots of the sum and difference radicands
  logic vb;
  logic [1:0][32:0] root_b;
  logic [SIDE_B_W-1:0] side_b;
  logic [prot_pkg::IN_DATA_W-1:0] fb;
  logic [64:0] k00_b;
  logic [64:0] k11_b;
  logic signed [65:0] c01_b;
  logic [63:0] sdc_b;

  prot_isqrt #(
    .LANES (2),
    .IN_W  (66),
    .SIDE_W(SIDE_B_W)
  ) u_sqrt_sv (
    .clk     (clk),
    .rst     (rst),
    .ctl     ('{en: en, vld: v7}),
    .rad     (rad7),
    .side_in (side_b7),
    .vld_out (vb),
    .root    (root_b),
    .side_out(side_b)
  );

  assign {sdc_b, c01_b, k11_b, k00_b, fb} = side_b;

  // stage 8: partial products of numerators and denominator, singular values
  logic v8;
  logic signed [64:0] uakl8 [3];
  logic signed [65:0] uakh8 [3];
  logic signed [64:0] ubcl8 [3];
  logic signed [65:0] ubch8 [3];
  logic signed [64:0] vbkl8 [3];
  logic signed [65:0] vbkh8 [3];
  logic signed [64:0] vacl8 [3];
  logic signed [65:0] vach8 [3];
  logic [64:0] dpl8;
  logic [64:0] dph8;
  logic [prot_pkg::SIG_W-1:0] smaj8;
  logic [prot_pkg::SIG_W-1:0] smin8;
  logic signed [31:0] ab_a [3];
  logic signed [31:0] ab_b [3];
  logic [32:0] den_c;
  logic [33:0] ssum;
  logic [32:0] sdif;

  always_comb begin
    for (int d = 0; d < 3; d++) begin
      ab_a[d] = fb[64*d +: 32];
      ab_b[d] = fb[64*d+32 +: 32];
    end
    den_c = (root_b[0] == 33'd0) ? 33'd1 : root_b[0];
    ssum  = {1'b0, root_b[0]} + {1'b0, root_b[1]};
    sdif  = root_b[0] - root_b[1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v8 <= 1'b0;
    end else if (en) begin
      v8 <= vb;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int d = 0; d < 3; d++) begin
        uakl8[d] <= ab_a[d] * $signed({1'b0, k00_b[31:0]});
        uakh8[d] <= ab_a[d] * $signed({1'b0, k00_b[64:32]});
        ubcl8[d] <= ab_b[d] * $signed({1'b0, c01_b[31:0]});
        ubch8[d] <= ab_b[d] * $signed(c01_b[65:32]);
        vbkl8[d] <= ab_b[d] * $signed({1'b0, k11_b[31:0]});
        vbkh8[d] <= ab_b[d] * $signed({1'b0, k11_b[64:32]});
        vacl8[d] <= ab_a[d] * $signed({1'b0, c01_b[31:0]});
        vach8[d] <= ab_a[d] * $signed(c01_b[65:32]);
      end
      dpl8  <= den_c * sdc_b[31:0];
      dph8  <= den_c * sdc_b[63:32];
      smaj8 <= (ssum[33:32] != 2'b00) ? {prot_pkg::SIG_W{1'b1}} : ssum[31:1];
      smin8 <= sdif[32] ? {prot_pkg::SIG_W{1'b1}} : sdif[31:1];
    end
  end

  // stage 9: full products and denominator
  logic v9;
  logic signed [97:0] pu9 [3];
  logic signed [97:0] qu9 [3];
  logic signed [97:0] pv9 [3];
  logic signed [97:0] qv9 [3];
  logic [96:0] den9;
  logic [prot_pkg::SIG_W-1:0] smaj9;
  logic [prot_pkg::SIG_W-1:0] smin9;

  always_ff @(posedge clk) begin
    if (rst) begin
      v9 <= 1'b0;
    end else if (en) begin
      v9 <= v8;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int d = 0; d < 3; d++) begin
        pu9[d] <= (98'(uakh8[d]) <<< 32) + 98'(uakl8[d]);
        qu9[d] <= (98'(ubch8[d]) <<< 32) + 98'(ubcl8[d]);
        pv9[d] <= (98'(vbkh8[d]) <<< 32) + 98'(vbkl8[d]);
        qv9[d] <= (98'(vach8[d]) <<< 32) + 98'(vacl8[d]);
      end
      den9  <= {dph8, 32'b0} + 97'(dpl8);
      smaj9 <= smaj8;
      smin9 <= smin8;
    end
  end

  // stage 10: numerators of the rotation entries
  logic v10;
  logic signed [97:0] num10 [6];
  logic [96:0] den10;
  logic [prot_pkg::SIG_W-1:0] smaj10;
  logic [prot_pkg::SIG_W-1:0] smin10;

  always_ff @(posedge clk) begin
    if (rst) begin
      v10 <= 1'b0;
    end else if (en) begin
      v10 <= v9;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int d = 0; d < 3; d++) begin
        num10[2*d]   <= pu9[d] - qu9[d];
        num10[2*d+1] <= pv9[d] - qv9[d];
      end
      den10  <= den9;
      smaj10 <= smaj9;
      smin10 <= smin9;
    end
  end

  // stage 11: magnitudes scaled to the output format
  logic v11;
  logic [5:0][127:0] n11;
  logic [5:0] neg11;
  logic [96:0] den11;
  logic [prot_pkg::SIG_W-1:0] smaj11;
  logic [prot_pkg::SIG_W-1:0] smin11;
  logic [97:0] mag_n [6];

  always_comb begin
    for (int k = 0; k < 6; k++) begin
      mag_n[k] = num10[k][97] ? 98'(-num10[k]) : num10[k];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v11 <= 1'b0;
    end else if (en) begin
      v11 <= v10;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 6; k++) begin
        n11[k]   <= 128'(mag_n[k]) << FRAC_BITS;
        neg11[k] <= num10[k][97];
      end
      den11  <= den10;
      smaj11 <= smaj10;
      smin11 <= smin10;
    end
  end

  // rotation quotients
  logic vd;
  logic [5:0][31:0] quo_d;
  logic [5:0] ovf_d;
  logic [SIDE_D_W-1:0] side_d;
  logic [5:0] neg_d;
  logic [prot_pkg::SIG_W-1:0] smaj_d;
  logic [prot_pkg::SIG_W-1:0] smin_d;

  prot_div #(
    .LANES (6),
    .N_W   (128),
    .D_W   (97),
    .Q_W   (32),
    .SIDE_W(SIDE_D_W)
  ) u_div (
    .clk     (clk),
    .rst     (rst),
    .ctl     ('{en: en, vld: v11}),
    .num     (n11),
    .dvs     (den11),
    .side_in ({neg11, smin11, smaj11}),
    .vld_out (vd),
    .quo     (quo_d),
    .ovf     (ovf_d),
    .side_out(side_d)
  );

  assign {neg_d, smin_d, smaj_d} = side_d;

  // output register with saturation and sign
  logic [31:0] r_n [6];

  always_comb begin
    for (int k = 0; k < 6; k++) begin
      logic [31:0] lim;
      logic [31:0] mag;
      lim = neg_d[k] ? 32'h8000_0000 : 32'h7FFF_FFFF;
      mag = (ovf_d[k] || quo_d[k] > lim) ? lim : quo_d[k];
      r_n[k] = neg_d[k] ? 32'd0 - mag : mag;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= vd;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_tdata <= {2'b00, smin_d, smaj_d, r_n[5], r_n[4], r_n[3], r_n[2], r_n[1], r_n[0]};
    end
  end

  // larger singular value never below the smaller one
  a_sig_order: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[222:192] >= m_tdata[253:223]))
    else $error("sig_major below sig_minor");

  // a held result blocks new input
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |-> !s_tready)
    else $error("input taken while output stalled");

  // a held result stays valid into the next cycle
  a_stall_keeps_valid: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> m_tvalid)
    else $error("stalled result dropped");

endmodule

[verif/polar_rotation_checker.sv]
// checker for the 3x2 polar rotation pipeline: predicts each rotation and compares results
module polar_rotation_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  input  logic                          s_tready,
  input  logic [prot_pkg::IN_DATA_W-1:0]  s_tdata,
  input  logic                          m_tvalid,
  input  logic                          m_tready,
  input  logic [prot_pkg::OUT_DATA_W-1:0] m_tdata,
  output int                            fails,
  output int                            pending,
  output int                            checked
);

  localparam int FB = prot_pkg::FRAC_BITS_DEF;

  typedef struct packed {
    logic [5:0][31:0]           rot;
    logic [prot_pkg::SIG_W-1:0] sig_major;
    logic [prot_pkg::SIG_W-1:0] sig_minor;
  } rotation_t;

  rotation_t expected_rotations[$];

  function automatic logic [63:0] floor_root(input logic [127:0] v);
    logic [63:0]  r;
    logic [63:0]  t;
    r = '0;
    for (int bit_i = 63; bit_i >= 0; bit_i--) begin
      t = r | (64'd1 << bit_i);
      if ({64'd0, t} * {64'd0, t} <= v) r = t;
    end
    return r;
  endfunction

  function automatic logic [31:0] scaled_ratio(input logic signed [127:0] num,
                                               input logic [127:0] denom);
    logic         neg;
    logic [127:0] mag;
    logic [127:0] q;
    logic [127:0] lim;
    neg = num[127];
    mag = neg ? -num : num;
    q = (mag << FB) / denom;
    lim = neg ? 128'h8000_0000 : 128'h7fff_ffff;
    if (q > lim) q = lim;
    return neg ? 32'(-q) : q[31:0];
  endfunction

  function automatic rotation_t predict_rotation(input logic [prot_pkg::IN_DATA_W-1:0] d);
    logic signed [127:0] a[3];
    logic signed [127:0] b[3];
    logic [127:0]        c00, c11, acc, tr, two_sd, k00, k11, denom, xprod;
    logic signed [127:0] c01, nu, nv;
    logic [63:0]         sd, den, dm, sd_c, den_c, m;
    rotation_t           res;
    for (int i = 0; i < 3; i++) begin
      a[i] = 128'(signed'(d[64*i +: 32]));
      b[i] = 128'(signed'(d[64*i+32 +: 32]));
    end
    c00 = '0; c11 = '0; c01 = '0; acc = '0;
    for (int i = 0; i < 3; i++) begin
      c00 += a[i] * a[i];
      c11 += b[i] * b[i];
      c01 += a[i] * b[i];
    end
    for (int i = 0; i < 3; i++) begin
      xprod = a[(i+1)%3] * b[(i+2)%3] - a[(i+2)%3] * b[(i+1)%3];
      m = xprod[127] ? 64'(-xprod) : xprod[63:0];
      acc += {64'd0, m} * {64'd0, m};
    end
    sd = floor_root(acc);
    tr = c00 + c11;
    two_sd = {63'd0, sd, 1'b0};
    den = floor_root(tr + two_sd);
    dm = (tr < two_sd) ? 64'd0 : floor_root(tr - two_sd);
    den_c = (den != 0) ? den : 64'd1;
    sd_c = (sd != 0) ? sd : 64'd1;
    denom = {64'd0, den_c} * {64'd0, sd_c};
    k00 = c11 + sd;
    k11 = c00 + sd;
    for (int i = 0; i < 3; i++) begin
      nu = signed'(k00) * a[i] - c01 * b[i];
      nv = signed'(k11) * b[i] - c01 * a[i];
      res.rot[2*i]   = scaled_ratio(nu, denom);
      res.rot[2*i+1] = scaled_ratio(nv, denom);
    end
    res.sig_major = ((den + dm) >> 1) > 64'h7fff_ffff ? 31'h7fff_ffff : 31'((den + dm) >> 1);
    res.sig_minor = ((den - dm) >> 1) > 64'h7fff_ffff ? 31'h7fff_ffff : 31'((den - dm) >> 1);
    return res;
  endfunction

  task automatic report(input string field, input logic [31:0] got, input logic [31:0] exp);
    $display("mismatch on result %0d, %s: got %h expected %h", checked, field, got, exp);
    fails++;
  endtask

  initial begin
    fails = 0;
    checked = 0;
  end

  assign pending = expected_rotations.size();

  always @(posedge clk) begin
    rotation_t exp_r;
    if (!rst) begin
      if (s_tvalid && s_tready)
        expected_rotations = {expected_rotations, predict_rotation(s_tdata)};
      if (m_tvalid && m_tready) begin
        if (expected_rotations.size() == 0) begin
          $display("unexpected result transfer: %h", m_tdata);
          fails++;
        end else begin
          exp_r = expected_rotations.pop_front();
          for (int i = 0; i < 6; i++)
            if (m_tdata[32*i +: 32] !== exp_r.rot[i])
              report($sformatf("rotation entry %0d", i), m_tdata[32*i +: 32], exp_r.rot[i]);
          if (m_tdata[222:192] !== exp_r.sig_major)
            report("sig_major", {1'b0, m_tdata[222:192]}, {1'b0, exp_r.sig_major});
          if (m_tdata[253:223] !== exp_r.sig_minor)
            report("sig_minor", {1'b0, m_tdata[253:223]}, {1'b0, exp_r.sig_minor});
          checked++;
        end
      end
    end
  end

endmodule

[verif/tb.sv]
// testbench top for the 3x2 polar rotation pipeline: stimulus, stalls and verdict
module tb;

  localparam int RANDOM_ITEMS = 1000;
  localparam int TAIL_ITEMS = 150;
  localparam int HOLD_CYCLES = 500;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam logic [31:0] ONE = 32'h0001_0000;
  localparam logic [31:0] MAXV = 32'h7fff_ffff;
  localparam logic [31:0] MINV = 32'h8000_0000;

  logic clk;
  logic rst;
  logic s_tvalid;
  logic s_tready;
  logic [prot_pkg::IN_DATA_W-1:0] s_tdata;
  logic m_tvalid;
  logic m_tready;
  logic [prot_pkg::OUT_DATA_W-1:0] m_tdata;
  int fails, pending, checked;
  int sent;
  int idle_cycles;
  logic stalls_on;
  logic hold_req;

  polar_rotation_3x2 dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  polar_rotation_checker chk (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .fails(fails), .pending(pending), .checked(checked)
  );

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  function automatic logic [191:0] gradient(input logic [31:0] xu, xv, yu, yv, zu, zv);
    return {zv, zu, yv, yu, xv, xu};
  endfunction

  function automatic logic [31:0] moderate();
    return 32'(signed'($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000);
  endfunction

  function automatic logic [191:0] random_gradient();
    logic [31:0] a[3];
    logic [31:0] b[3];
    int k;
    case ($urandom_range(0, 9))
      0, 1: begin
        for (int i = 0; i < 3; i++) begin a[i] = $urandom; b[i] = $urandom; end
      end
      6: begin
        for (int i = 0; i < 3; i++) begin
          a[i] = 32'($urandom_range(0, 511)) - 32'd255;
          b[i] = 32'($urandom_range(0, 511)) - 32'd255;
        end
      end
      7: begin
        k = $urandom_range(0, 6) - 3;
        for (int i = 0; i < 3; i++) begin a[i] = moderate(); b[i] = 32'(signed'(a[i]) * k); end
      end
      8: begin
        for (int i = 0; i < 3; i++) a[i] = moderate();
        b[0] = -a[1]; b[1] = a[0]; b[2] = moderate() >>> 4;
      end
      9: begin
        for (int i = 0; i < 3; i++) begin
          a[i] = $urandom_range(0, 1) ? MAXV - $urandom_range(0, 255) : MINV + $urandom_range(0, 255);
          b[i] = $urandom;
        end
      end
      default: begin
        for (int i = 0; i < 3; i++) begin a[i] = moderate(); b[i] = moderate(); end
      end
    endcase
    return gradient(a[0], b[0], a[1], b[1], a[2], b[2]);
  endfunction

  task automatic send(input logic [191:0] d);
    s_tvalid <= 1'b1;
    s_tdata <= d;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sent++;
    if (stalls_on && $urandom_range(0, 7) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
  endtask

  // receiver: random stall bursts, one long hold to back up the pipeline
  initial begin
    m_tready = 1'b0;
    @(negedge rst);
    forever begin
      if (hold_req) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else if (stalls_on && $urandom_range(0, 5) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end else begin
        m_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
               idle_cycles, pending);
      $display("tb NOT OK");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    sent = 0;
    idle_cycles = 0;
    stalls_on = 1'b1;
    hold_req = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send(gradient(0, 0, 0, 0, 0, 0));
    send(gradient(ONE, 0, 0, ONE, 0, 0));
    send(gradient(0, ONE, ONE, 0, 0, 0));
    send(gradient(ONE, ONE, ONE, ONE, ONE, ONE));
    send(gradient(ONE, 0, 0, 0, 0, 0));
    send(gradient(0, 0, 0, 0, 0, ONE));
    send(gradient(1, 0, 0, 1, 0, 0));
    send(gradient(1, 1, 0, 0, 0, 0));
    send(gradient(MAXV, MAXV, MAXV, MAXV, MAXV, MAXV));
    send(gradient(MINV, MINV, MINV, MINV, MINV, MINV));
    send(gradient(MAXV, 0, 0, MAXV, 0, 0));
    send(gradient(MINV, 0, 0, MINV, 0, 0));
    send(gradient(MAXV, MINV, MINV, MAXV, MAXV, MINV));
    send(gradient(MINV, MAXV, MAXV, MINV, MINV, MAXV));
    send(gradient(32'hffff_ffff, 1, 1, 32'hffff_ffff, 0, 0));
    send(gradient(-ONE, 0, 0, ONE, 0, 0));
    send(gradient(32'h0000_b505, 32'hffff_4afb, 32'h0000_b505, 32'h0000_b505, 0, 0));
    send(gradient(2 * ONE, 0, 0, ONE >> 1, 0, ONE >> 2));
    send(gradient(MAXV, 1, 0, 1, 0, 0));
    send(gradient(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
                  32'hffff_ffff, 32'hffff_ffff));

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == 300) hold_req = 1'b1;
      if (i == RANDOM_ITEMS - TAIL_ITEMS) stalls_on = 1'b0;
      send(random_gradient());
    end
    s_tvalid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("sent %0d gradients (zero, identity, rank-one, full-scale and random), %0d checked",
             sent, checked);
    $display("with random stalls on both channels and one long output hold");
    if (fails == 0) $display("tb OK");
    else $display("tb NOT OK");
    $finish;
  end

endmodule

[filelist.f]
rtl/prot_pkg.sv
rtl/prot_isqrt.sv
rtl/prot_div.sv
rtl/polar_rotation_3x2.sv
verif/polar_rotation_checker.sv
verif/tb.sv
